FILE: rtl/core/iht_pkg.sv
// Shared types and constants of the hill climb tracker.
`timescale 1ns / 1ps
package iht_pkg;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TRACK = 1'b1;

  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_NO_FRAME = 2'd1;
  localparam logic [1:0] ST_BORDER   = 2'd2;

  localparam logic [2:0] REG_LAMBDA = 3'd0;
  localparam logic [2:0] REG_SIGMA  = 3'd1;
  localparam logic [2:0] REG_MARGIN = 3'd2;
  localparam logic [2:0] REG_WIDTH  = 3'd3;
  localparam logic [2:0] REG_HEIGHT = 3'd4;

  localparam int CFG_BITS = 16;
  localparam int IDX_BITS = 3;

  typedef struct packed {
    logic              operation;
    logic [8:0]        pos_x;
    logic [8:0]        pos_y;
    logic signed [15:0] pixel_value;
  } request_t;

  typedef struct packed {
    logic [8:0] best_x;
    logic [8:0] best_y;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic       load;
    logic       write;
    logic       rd;
    logic       div_init;
    logic       div_step;
    logic       mul;
    logic       accum;
    logic       nbr_next;
    logic       take;
    logic       emit;
    logic [1:0] code;
  } cmd_t;

  typedef struct packed {
    logic start_ok;
    logic nbr_inside;
    logic nbr_last;
    logic div_done;
    logic improve;
  } stat_t;

  typedef struct packed {
    logic signed [1:0] dx;
    logic signed [1:0] dy;
  } off_t;

  // Neighbor scan order: rows top to bottom, columns left to right, center skipped.
  function automatic off_t nbr_off(input logic [2:0] k);
    off_t o;
    unique case (k)
      3'd0: o = '{dx: -2'sd1, dy: -2'sd1};
      3'd1: o = '{dx:  2'sd0, dy: -2'sd1};
      3'd2: o = '{dx:  2'sd1, dy: -2'sd1};
      3'd3: o = '{dx: -2'sd1, dy:  2'sd0};
      3'd4: o = '{dx:  2'sd1, dy:  2'sd0};
      3'd5: o = '{dx: -2'sd1, dy:  2'sd1};
      3'd6: o = '{dx:  2'sd0, dy:  2'sd1};
      3'd7: o = '{dx:  2'sd1, dy:  2'sd1};
      default: o = '{dx: 2'sd0, dy: 2'sd0};
    endcase
    return o;
  endfunction

endpackage

FILE: rtl/core/image_hill_climb_tracker.sv
// Top level of the eight-neighbor hill climb peak tracker.
`timescale 1ns / 1ps
// Usage:
//   A request is taken on the rising edge where start is high and busy low.
//   A request with operation write stores pixel_value at (pos_x, pos_y)
//   and gives no result; busy stays low.
//   A request with operation track climbs from (pos_x, pos_y) over the
//   eight neighbors of the best point and gives one result: done is high
//   for exactly one cycle with best_x, best_y and status on result.
//   A rejected start is turned away in the check state, and done is
//   registered from there. Each scored neighbor passes a bounds check and
//   read, divider init, 16 divider steps, a multiply and a compare; a full
//   scan of eight neighbors ends in the climb decision, and the serial
//   restoring divider takes most of the steps. A climb that hits the
//   border stops at the first neighbor outside. A new request is taken
//   once busy drops.
//   Configuration is written through cfg_write, cfg_index and cfg_data by the
//   user only while no query runs; the block does not enforce this. Unknown
//   indexes are dropped. Reset (rst, synchronous) restores register defaults
//   and clears the frame loaded flag; the store is kept. Results cannot be held off.
module image_hill_climb_tracker #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int PIXEL_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  iht_pkg::request_t            request,
  output logic                         done,
  output iht_pkg::result_t             result,
  input  logic                         cfg_write,
  input  logic [iht_pkg::IDX_BITS-1:0] cfg_index,
  input  logic [iht_pkg::CFG_BITS-1:0] cfg_data
);
  import iht_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequence the climb
  iht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (request.operation),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  // Hold the frame, score neighbors and register the result
  iht_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (request),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result),
    .done      (done)
  );

  // A result only shows once the sequencer is back to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // Every result follows a query that was in flight.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a running query");

  // Results are single-cycle strobes.
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  // Status stays within its defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == ST_FOUND || result.status == ST_NO_FRAME ||
              result.status == ST_BORDER))
    else $error("undefined status code");

endmodule

FILE: rtl/core/iht_ctrl.sv
// Sequencer of the climb: walks neighbors, divider steps and climb steps.
`timescale 1ns / 1ps
module iht_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          operation,
  input  iht_pkg::stat_t stat,
  output iht_pkg::cmd_t  cmd,
  output logic          busy
);
  import iht_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_CHK  = 8'b00000010,
    S_NBR  = 8'b00000100,
    S_RD   = 8'b00001000,
    S_DIV  = 8'b00010000,
    S_MUL  = 8'b00100000,
    S_ACC  = 8'b01000000,
    S_STEP = 8'b10000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    cmd.code = ST_FOUND;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (operation == OP_TRACK) begin
            cmd.load = 1'b1;
            state_next = S_CHK;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      S_CHK: begin
        if (stat.start_ok) begin
          state_next = S_NBR;
        end else begin
          cmd.emit = 1'b1;
          cmd.code = ST_NO_FRAME;
          state_next = S_IDLE;
        end
      end
      S_NBR: begin
        if (stat.nbr_inside) begin
          cmd.rd = 1'b1;
          state_next = S_RD;
        end else begin
          cmd.emit = 1'b1;
          cmd.code = ST_BORDER;
          state_next = S_IDLE;
        end
      end
      S_RD: begin
        cmd.div_init = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.accum = 1'b1;
        if (stat.nbr_last) begin
          state_next = S_STEP;
        end else begin
          cmd.nbr_next = 1'b1;
          state_next = S_NBR;
        end
      end
      S_STEP: begin
        if (stat.improve) begin
          cmd.take = 1'b1;
          state_next = S_NBR;
        end else begin
          cmd.emit = 1'b1;
          cmd.code = ST_FOUND;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

FILE: rtl/core/iht_datapath.sv
// Frame store, registers, neighbor scoring, divider and result register.
`timescale 1ns / 1ps
module iht_datapath #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int PIXEL_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [iht_pkg::IDX_BITS-1:0]       cfg_index,
  input  logic [iht_pkg::CFG_BITS-1:0]       cfg_data,
  input  iht_pkg::request_t                  request,
  input  iht_pkg::cmd_t                      cmd,
  output iht_pkg::stat_t                     stat,
  output iht_pkg::result_t                   result,
  output logic                               done
);
  import iht_pkg::*;

  localparam int XB = $clog2(MAX_WIDTH);
  localparam int YB = $clog2(MAX_HEIGHT);
  localparam int AB = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int LB = (XB > YB) ? XB : YB;
  localparam int CB = ((LB > 10) ? LB : 10) + 2;
  localparam int EB = CB + 1;
  localparam int SQ = 2 * EB;
  localparam int DW = SQ + 1;
  localparam int NW = DW + 17;
  localparam int TW = NW + 15;
  localparam int SW = PIXEL_BITS + 18;

  logic [15:0] lambda_gain, sigma_squared;
  logic [7:0]  border_margin;
  logic [9:0]  frame_width, frame_height;
  logic        frame_loaded;

  logic signed [CB-1:0] sx, sy, bx, by, nx, ny, cx, cy, wlim, hlim, marg;
  logic [2:0]           k;
  logic                 first, nvalid;
  logic signed [SW-1:0] best, nscore, score_c;
  logic signed [PIXEL_BITS-1:0] pix_q;
  logic [DW-1:0]        d2_q, d2_c;
  logic signed [EB-1:0] ddx, ddy;
  logic [SQ-1:0]        sqx, sqy;
  logic [NW-1:0]        den;
  logic [31:0]          rem;
  logic [TW-1:0]        dsh;
  logic [15:0]          quo;
  logic [3:0]           cnt;
  logic [16:0]          reg17;
  logic [24:0]          bonus;
  logic [32:0]          prod;
  logic [AB-1:0]        raddr, waddr;
  logic signed [31:0]   wide_pix;
  off_t                 off;

  logic [PIXEL_BITS-1:0] mem [MAX_WIDTH * MAX_HEIGHT];

  function automatic logic in_frame(input logic signed [CB-1:0] x, y, m, w, h);
    return (x >= m) && (y >= m) && ((x + m) < w) && ((y + m) < h);
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lambda_gain   <= 16'd256;
      sigma_squared <= 16'd655;
      border_margin <= 8'd0;
      frame_width   <= 10'd512;
      frame_height  <= 10'd512;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LAMBDA: lambda_gain   <= cfg_data;
        REG_SIGMA:  sigma_squared <= cfg_data;
        REG_MARGIN: border_margin <= cfg_data[7:0];
        REG_WIDTH:  frame_width   <= cfg_data[9:0];
        REG_HEIGHT: frame_height  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  assign wlim = (int'(frame_width) > MAX_WIDTH) ? CB'(MAX_WIDTH) : CB'(frame_width);
  assign hlim = (int'(frame_height) > MAX_HEIGHT) ? CB'(MAX_HEIGHT) : CB'(frame_height);
  assign marg = CB'(border_margin);

  assign off = nbr_off(k);
  assign cx  = bx + CB'(off.dx);
  assign cy  = by + CB'(off.dy);

  assign ddx  = EB'(cx) - EB'(sx);
  assign ddy  = EB'(cy) - EB'(sy);
  assign sqx  = SQ'(ddx * ddx);
  assign sqy  = SQ'(ddy * ddy);
  assign d2_c = DW'(sqx) + DW'(sqy);

  assign raddr = AB'(cy[YB-1:0]) * AB'(MAX_WIDTH) + AB'(cx[XB-1:0]);
  assign waddr = AB'(YB'(request.pos_y % MAX_HEIGHT)) * AB'(MAX_WIDTH)
               + AB'(XB'(request.pos_x % MAX_WIDTH));
  assign wide_pix = 32'(request.pixel_value);

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[waddr] <= wide_pix[PIXEL_BITS-1:0];
    end
    if (cmd.rd) begin
      pix_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_loaded <= 1'b0;
    end else if (cmd.write) begin
      frame_loaded <= 1'b1;
    end
  end

  // Climb position and neighbor bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      first  <= 1'b1;
      nvalid <= 1'b0;
      k      <= '0;
    end else begin
      if (cmd.load) begin
        sx     <= CB'(request.pos_x);
        sy     <= CB'(request.pos_y);
        bx     <= CB'(request.pos_x);
        by     <= CB'(request.pos_y);
        first  <= 1'b1;
        nvalid <= 1'b0;
        k      <= '0;
      end
      if (cmd.rd) begin
        d2_q <= d2_c;
      end
      if (cmd.accum && (!nvalid || nscore <= score_c)) begin
        nscore <= score_c;
        nx     <= cx;
        ny     <= cy;
        nvalid <= 1'b1;
      end
      if (cmd.nbr_next) begin
        k <= k + 3'd1;
      end
      if (cmd.take) begin
        bx     <= nx;
        by     <= ny;
        best   <= nscore;
        first  <= 1'b0;
        nvalid <= 1'b0;
        k      <= '0;
      end
    end
  end

  // Restoring divider, one quotient bit per cycle
  assign den = NW'(sigma_squared) + (NW'(d2_q) << 16);

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem <= {sigma_squared, 16'd0};
      dsh <= TW'(den) << 15;
      quo <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      if (TW'(rem) >= dsh) begin
        rem <= rem - dsh[31:0];
        quo <= {quo[14:0], 1'b1};
      end else begin
        quo <= {quo[14:0], 1'b0};
      end
      dsh <= dsh >> 1;
      cnt <= cnt + 4'd1;
    end
  end

  assign reg17 = (sigma_squared == 16'd0) ? 17'd0 :
                 (d2_q == '0) ? 17'h10000 : {1'b0, quo};
  assign prod  = 33'(lambda_gain) * 33'(reg17);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      bonus <= prod[32:8];
    end
  end

  assign score_c = (SW'(pix_q) <<< 16) + $signed(SW'(bonus));

  assign stat.start_ok   = frame_loaded && in_frame(sx, sy, marg, wlim, hlim);
  assign stat.nbr_inside = in_frame(cx, cy, marg, wlim, hlim);
  assign stat.nbr_last   = (k == 3'd7);
  assign stat.div_done   = (cnt == 4'd15);
  assign stat.improve    = first || (nscore > best);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
    if (cmd.emit) begin
      result.status <= cmd.code;
      if (cmd.code == ST_NO_FRAME) begin
        result.best_x <= '0;
        result.best_y <= '0;
      end else begin
        result.best_x <= bx[8:0];
        result.best_y <= by[8:0];
      end
    end
  end

endmodule
